// ===== rtl/mea_pkg.sv =====
// Package for the meter energy accumulator.
// Holds widths, scale constants, list type codes and the lane control struct.
// No dependencies.
package mea_pkg;

  // Datapath widths
  localparam int ACC_WIDTH   = 64;
  localparam int TIME_WIDTH  = 32;
  localparam int POWER_WIDTH = 16;
  localparam int METER_WIDTH = 40;

  // Watt-milliseconds per watt-hour
  localparam longint unsigned WMS_PER_WH_VAL = 64'd3600000;
  localparam int WMS_W = $clog2(WMS_PER_WH_VAL + 1);
  localparam logic [WMS_W-1:0] WMS_PER_WH = WMS_W'(WMS_PER_WH_VAL);

  // Product widths and the common width used for the saturation compares
  localparam int PROD_W  = TIME_WIDTH + POWER_WIDTH;
  localparam int PEXT_W  = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;
  localparam int MPROD_W = METER_WIDTH + WMS_W;
  localparam int MEXT_W  = (MPROD_W > ACC_WIDTH) ? MPROD_W : ACC_WIDTH;

  // Report detail levels
  typedef enum logic [1:0] {
    LT_BASIC    = 2'd0,
    LT_IMPORT   = 2'd1,
    LT_FULL     = 2'd2,
    LT_COUNTERS = 2'd3
  } list_type_e;

  // Per-lane update control
  typedef struct packed {
    logic add_en;   // add interval times power
    logic load_en;  // load from the meter counter
  } lane_ctrl_t;

endpackage

// ===== rtl/mea_report_if.sv =====
// Report channel interface: valid/ready plus one meter report word.
// Depends on mea_pkg.
interface mea_report_if;
  import mea_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             list_type;
  logic [TIME_WIDTH-1:0]  time_ms;
  logic [POWER_WIDTH-1:0] act_imp_watts;
  logic [POWER_WIDTH-1:0] act_exp_watts;
  logic [POWER_WIDTH-1:0] react_imp_var;
  logic [POWER_WIDTH-1:0] react_exp_var;
  logic [METER_WIDTH-1:0] meter_act_imp_wh;
  logic [METER_WIDTH-1:0] meter_act_exp_wh;
  logic [METER_WIDTH-1:0] meter_react_imp_wh;
  logic [METER_WIDTH-1:0] meter_react_exp_wh;

  modport source (
    output valid, list_type, time_ms, act_imp_watts, act_exp_watts,
           react_imp_var, react_exp_var, meter_act_imp_wh, meter_act_exp_wh,
           meter_react_imp_wh, meter_react_exp_wh,
    input  ready
  );

  modport sink (
    input  valid, list_type, time_ms, act_imp_watts, act_exp_watts,
           react_imp_var, react_exp_var, meter_act_imp_wh, meter_act_exp_wh,
           meter_react_imp_wh, meter_react_exp_wh,
    output ready
  );
endinterface

// ===== rtl/mea_result_if.sv =====
// Result channel interface: valid/ready plus one energy result word.
// Depends on mea_pkg.
interface mea_result_if;
  import mea_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACC_WIDTH-1:0] act_imp_energy;
  logic [ACC_WIDTH-1:0] act_exp_energy;
  logic [ACC_WIDTH-1:0] react_imp_energy;
  logic [ACC_WIDTH-1:0] react_exp_energy;
  logic                 is_estimated;
  logic [1:0]           best_list_type;

  modport source (
    output valid, act_imp_energy, act_exp_energy, react_imp_energy,
           react_exp_energy, is_estimated, best_list_type,
    input  ready
  );

  modport sink (
    input  valid, act_imp_energy, act_exp_energy, react_imp_energy,
           react_exp_energy, is_estimated, best_list_type,
    output ready
  );
endinterface

// ===== rtl/mea_lane.sv =====
// One energy lane: saturating multiply-accumulate or saturating counter load.
// Depends on mea_pkg.
module mea_lane (
  input  logic [mea_pkg::ACC_WIDTH-1:0]   acc_i,
  input  logic [mea_pkg::TIME_WIDTH-1:0]  dt_i,
  input  logic [mea_pkg::POWER_WIDTH-1:0] pwr_i,
  input  logic [mea_pkg::METER_WIDTH-1:0] meter_i,
  input  mea_pkg::lane_ctrl_t             ctrl_i,
  output logic [mea_pkg::ACC_WIDTH-1:0]   acc_o
);
  import mea_pkg::*;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  logic [PROD_W-1:0]    prod;
  logic [PEXT_W-1:0]    prod_ext;
  logic [ACC_WIDTH-1:0] prod_sat;
  logic [ACC_WIDTH:0]   sum;
  logic [ACC_WIDTH-1:0] sum_sat;
  logic [MPROD_W-1:0]   mprod;
  logic [MEXT_W-1:0]    mprod_ext;
  logic [ACC_WIDTH-1:0] load_sat;

  // Interval times power, clamped to the accumulator range
  assign prod     = PROD_W'(dt_i) * PROD_W'(pwr_i);
  assign prod_ext = PEXT_W'(prod);
  assign prod_sat = (prod_ext > PEXT_W'(ACC_MAX)) ? ACC_MAX : prod_ext[ACC_WIDTH-1:0];

  // Saturating accumulate
  assign sum     = {1'b0, acc_i} + {1'b0, prod_sat};
  assign sum_sat = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];

  // Meter counter scaled from Wh to W*ms, clamped
  assign mprod     = MPROD_W'(meter_i) * MPROD_W'(WMS_PER_WH);
  assign mprod_ext = MEXT_W'(mprod);
  assign load_sat  = (mprod_ext > MEXT_W'(ACC_MAX)) ? ACC_MAX
                                                    : mprod_ext[ACC_WIDTH-1:0];

  // Select the lane update
  always_comb begin
    if (ctrl_i.load_en) begin
      acc_o = load_sat;
    end else if (ctrl_i.add_en) begin
      acc_o = sum_sat;
    end else begin
      acc_o = acc_i;
    end
  end

endmodule

// ===== rtl/meter_energy_accumulator.sv =====
// Top level of the meter energy accumulator: input register, report state,
// four energy lanes and the result register.
// Depends on mea_pkg, mea_report_if, mea_result_if and mea_lane.
//
//   channel   dir  modport  word
//   rpt_i     in   sink     one meter report (type, time, powers, counters)
//   res_o     out  source   four energies, estimate flag, best list type
//
// A report moves from the input register through the combinational lane
// multiply-accumulate into the accumulators and the result register; one
// report is taken every cycle unless the result stalls.
// Reset clears the accumulators, timestamps, flag and highest type.
// A stalled result holds its register; the input register still takes one
// more report, and the channel then backs up until the result is taken.
module meter_energy_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  mea_report_if.sink   rpt_i,
  mea_result_if.source res_o
);
  import mea_pkg::*;

  localparam int NUM_LANES = 4;

  // Input register
  logic                   rpt_vld_q;
  logic [1:0]             type_q;
  logic [TIME_WIDTH-1:0]  time_q;
  logic [POWER_WIDTH-1:0] pwr_q   [NUM_LANES];
  logic [METER_WIDTH-1:0] meter_q [NUM_LANES];

  // Report state
  logic [TIME_WIDTH-1:0] last_q, last_full_q;
  logic [ACC_WIDTH-1:0]  acc_q [NUM_LANES];
  logic [ACC_WIDTH-1:0]  acc_d [NUM_LANES];
  logic                  est_q, est_d;
  logic [1:0]            high_q, high_d;

  // Result register
  logic                  res_vld_q;

  logic                  advance;
  logic                  ts_pos;
  logic [TIME_WIDTH-1:0] dt, dtf;
  lane_ctrl_t            ctrl [NUM_LANES];

  // Handshake
  assign advance     = rpt_vld_q && (!res_vld_q || res_o.ready);
  assign rpt_i.ready = !rpt_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_vld_q <= 1'b0;
    end else if (rpt_i.valid && rpt_i.ready) begin
      rpt_vld_q <= 1'b1;
    end else if (advance) begin
      rpt_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpt_i.valid && rpt_i.ready) begin
      type_q     <= rpt_i.list_type;
      time_q     <= rpt_i.time_ms;
      pwr_q[0]   <= rpt_i.act_imp_watts;
      pwr_q[1]   <= rpt_i.act_exp_watts;
      pwr_q[2]   <= rpt_i.react_imp_var;
      pwr_q[3]   <= rpt_i.react_exp_var;
      meter_q[0] <= rpt_i.meter_act_imp_wh;
      meter_q[1] <= rpt_i.meter_act_exp_wh;
      meter_q[2] <= rpt_i.meter_react_imp_wh;
      meter_q[3] <= rpt_i.meter_react_exp_wh;
    end
  end

  // Intervals: import since any report, others since last full or counters report
  assign ts_pos = time_q > last_q;
  assign dt     = time_q - last_q;
  assign dtf    = (last_full_q > time_q) ? '0 : time_q - last_full_q;

  // Lane control
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      ctrl[i].load_en = (type_q == LT_COUNTERS);
      if (i == 0) begin
        ctrl[i].add_en = (type_q != LT_COUNTERS) && ts_pos;
      end else begin
        ctrl[i].add_en = (type_q == LT_FULL) && ts_pos;
      end
    end
  end

  // Energy lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mea_lane u_lane (
      .acc_i   (acc_q[g]),
      .dt_i    ((g == 0) ? dt : dtf),
      .pwr_i   (pwr_q[g]),
      .meter_i (meter_q[g]),
      .ctrl_i  (ctrl[g]),
      .acc_o   (acc_d[g])
    );
  end

  // Flag and highest type
  always_comb begin
    est_d = est_q;
    if (type_q == LT_COUNTERS) begin
      est_d = 1'b0;
    end else if (ts_pos) begin
      est_d = 1'b1;
    end
    high_d = (type_q > high_q) ? type_q : high_q;
  end

  // State update as the report moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      last_full_q <= '0;
      est_q       <= 1'b0;
      high_q      <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (advance) begin
      last_q <= time_q;
      if (type_q == LT_FULL || type_q == LT_COUNTERS) begin
        last_full_q <= time_q;
      end
      est_q  <= est_d;
      high_q <= high_d;
      for (int i = 0; i < NUM_LANES; i++) begin
        acc_q[i] <= acc_d[i];
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // The accumulator state after the last report is the result word
  assign res_o.valid            = res_vld_q;
  assign res_o.act_imp_energy   = acc_q[0];
  assign res_o.act_exp_energy   = acc_q[1];
  assign res_o.react_imp_energy = acc_q[2];
  assign res_o.react_exp_energy = acc_q[3];
  assign res_o.is_estimated     = est_q;
  assign res_o.best_list_type   = high_q;

  // Checks
  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rpt_i.ready |-> (rpt_vld_q && res_vld_q && !res_o.ready))
    else $error("report channel stalled without a full pipeline");

  a_counters_clear_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && type_q == LT_COUNTERS) |=> !res_o.is_estimated)
    else $error("counter report left the estimate flag set");

  a_add_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && type_q != LT_COUNTERS && ts_pos) |=> (res_o.valid && res_o.is_estimated))
    else $error("integrating report did not set the estimate flag");

  a_best_type_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (high_q >= $past(high_q)))
    else $error("best list type decreased");

endmodule

// ===== sim/tb.sv =====
// Testbench for meter_energy_accumulator: drives meter reports through the report channel,
// predicts the energy result word per report and checks each one against the result channel.
// Depends on mea_pkg, mea_report_if, mea_result_if and the accumulator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mea_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    list_type_e                        lt;
    logic [TIME_WIDTH-1:0]             t;
    logic [3:0][POWER_WIDTH-1:0]       pw;
    logic [3:0][METER_WIDTH-1:0]       wh;
  } report_t;

  typedef struct packed {
    logic [3:0][ACC_WIDTH-1:0] energy;
    logic                      est;
    logic [1:0]                best;
  } energy_word_t;

  logic clk;
  logic rst_n;

  mea_report_if rpt ();
  mea_result_if res ();

  meter_energy_accumulator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rpt_i  (rpt),
    .res_o  (res)
  );

  // Predicted accumulator state
  logic [ACC_WIDTH-1:0]  mdl_energy [4];
  logic [TIME_WIDTH-1:0] mdl_last_ms;
  logic [TIME_WIDTH-1:0] mdl_last_full_ms;
  logic                  mdl_estimated;
  logic [1:0]            mdl_best;

  energy_word_t          energy_q [$];
  int                    errors;
  bit                    src_idle;
  bit                    snk_idle;
  bit                    hold_req;
  logic [TIME_WIDTH-1:0] stim_ms;

  string lane_name [4] = '{"act_imp_energy", "act_exp_energy",
                           "react_imp_energy", "react_exp_energy"};

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Clamp a wide value to the accumulator range
  function automatic logic [ACC_WIDTH-1:0] clamp_acc(input logic [127:0] v);
    if ((v >> ACC_WIDTH) != 0) return {ACC_WIDTH{1'b1}};
    return v[ACC_WIDTH-1:0];
  endfunction

  // Advance the predicted state by one report and return the result word
  function automatic energy_word_t integrate_report(input report_t r);
    energy_word_t          w;
    logic [TIME_WIDTH-1:0] dt;
    logic [TIME_WIDTH-1:0] dtf;
    int                    i;
    if (r.lt != LT_COUNTERS) begin
      if (r.t > mdl_last_ms) begin
        dt = r.t - mdl_last_ms;
        mdl_energy[0] = clamp_acc(128'(mdl_energy[0]) + 128'(dt) * 128'(r.pw[0]));
        if (r.lt == LT_FULL) begin
          dtf = (mdl_last_full_ms > r.t) ? '0 : r.t - mdl_last_full_ms;
          for (i = 1; i < 4; i++) begin
            mdl_energy[i] = clamp_acc(128'(mdl_energy[i]) + 128'(dtf) * 128'(r.pw[i]));
          end
        end
        mdl_estimated = 1'b1;
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        mdl_energy[i] = clamp_acc(128'(r.wh[i]) * 128'(WMS_PER_WH_VAL));
      end
      mdl_estimated = 1'b0;
    end
    mdl_last_ms = r.t;
    if (r.lt >= LT_FULL) mdl_last_full_ms = r.t;
    if (r.lt > mdl_best) mdl_best = r.lt;
    for (i = 0; i < 4; i++) w.energy[i] = mdl_energy[i];
    w.est  = mdl_estimated;
    w.best = mdl_best;
    return w;
  endfunction

  // Random report, mostly advancing time with some zero, backward and wild jumps
  function automatic report_t random_report();
    report_t r;
    int      k;
    int      c;
    k = $urandom_range(0, 99);
    r.lt = list_type_e'((k < 10) ? LT_BASIC : (k < 45) ? LT_IMPORT :
                        (k < 85) ? LT_FULL : LT_COUNTERS);
    k = $urandom_range(0, 99);
    if (k < 80) begin
      if ($urandom_range(0, 3) == 0) stim_ms += $urandom_range(1, 1 << 24);
      else stim_ms += $urandom_range(1, 60000);
    end else if (k < 86) begin
      stim_ms = stim_ms;
    end else if (k < 93) begin
      stim_ms -= $urandom_range(1, 65535);
    end else begin
      stim_ms = $urandom();
    end
    r.t = stim_ms;
    for (c = 0; c < 4; c++) begin
      k = $urandom_range(0, 9);
      if (k == 0) r.pw[c] = {POWER_WIDTH{1'b0}};
      else if (k == 1) r.pw[c] = {POWER_WIDTH{1'b1}};
      else r.pw[c] = POWER_WIDTH'($urandom());
      r.wh[c] = METER_WIDTH'({$urandom(), $urandom()});
    end
    return r;
  endfunction

  // Offer one report word, wait for the handshake, then log its prediction
  task automatic send_report(input report_t r);
    int gap;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      rpt.valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    rpt.valid              <= 1'b1;
    rpt.list_type          <= r.lt;
    rpt.time_ms            <= r.t;
    rpt.act_imp_watts      <= r.pw[0];
    rpt.act_exp_watts      <= r.pw[1];
    rpt.react_imp_var      <= r.pw[2];
    rpt.react_exp_var      <= r.pw[3];
    rpt.meter_act_imp_wh   <= r.wh[0];
    rpt.meter_act_exp_wh   <= r.wh[1];
    rpt.meter_react_imp_wh <= r.wh[2];
    rpt.meter_react_exp_wh <= r.wh[3];
    do @(posedge clk); while (!rpt.ready);
    energy_q.push_back(integrate_report(r));
  endtask

  // Report with one power on all channels and one value in all counters
  task automatic send_simple(input list_type_e lt, input logic [TIME_WIDTH-1:0] t,
                             input logic [POWER_WIDTH-1:0] p,
                             input logic [METER_WIDTH-1:0] wh);
    report_t r;
    r.lt = lt;
    r.t  = t;
    r.pw = {4{p}};
    r.wh = {4{wh}};
    stim_ms = t;
    send_report(r);
  endtask

  // Field extremes and each interval corner
  task automatic test_directed();
    send_simple(LT_IMPORT, 0, '1, '1);               // zero interval right after reset
    send_simple(LT_IMPORT, 1000, '1, '0);
    send_simple(LT_BASIC, 2000, 16'h5555, '0);       // basic acts like import only
    send_simple(LT_FULL, 3000, '1, '0);
    send_simple(LT_FULL, 3000, '1, '0);              // zero interval
    send_simple(LT_IMPORT, 2500, '1, '0);            // backward interval
    send_simple(LT_FULL, 4000, 16'hAAAA, '0);        // full interval shorter than import
    send_simple(LT_COUNTERS, 5000, '1, '1);          // load largest counters
    send_simple(LT_BASIC, 5000, '1, '0);             // zero interval keeps flag clear
    send_simple(LT_IMPORT, 6000, '0, '0);            // zero power still marks estimate
    send_simple(LT_COUNTERS, 6500, '0, '0);
    send_simple(LT_FULL, 100000, 16'h5555, 40'hAA_AAAA_AAAA);
    send_simple(LT_IMPORT, 50000, 16'h0001, '0);     // import goes back, full stays ahead
    send_simple(LT_FULL, 60000, '1, '0);             // full interval backward
    send_simple(LT_COUNTERS, 70000, '0, 40'h55_5555_5555);
    send_simple(LT_COUNTERS, 80000, '0, 40'hAA_AAAA_AAAA);
    send_simple(LT_BASIC, 0, '1, '0);
    send_simple(LT_FULL, 32'hFFFF_FFFF, '1, '0);     // widest interval at full power
    send_simple(LT_IMPORT, 32'hFFFF_FFFF, '1, '1);
    send_simple(LT_FULL, 32'h5555_5555, 16'h5555, '0);
    send_simple(LT_FULL, 32'hAAAA_AAAA, 16'hAAAA, 40'h55_5555_5555);
  endtask

  // Long random stream with idling on both sides
  task automatic test_random(input int count);
    int n;
    for (n = 0; n < count; n++) send_report(random_report());
  endtask

  // Result side holds off while reports keep coming, so the input backs up
  task automatic test_backpressure();
    int n;
    src_idle = 1'b0;
    hold_req = 1'b1;
    for (n = 0; n < 40; n++) send_report(random_report());
    src_idle = 1'b1;
  endtask

  // Back-to-back reports with no idling
  task automatic test_full_rate();
    int n;
    src_idle = 1'b0;
    snk_idle = 1'b0;
    for (n = 0; n < 150; n++) send_report(random_report());
  endtask

  // Result ready: random stall bursts and the long hold-off on request
  initial begin : sink_ready
    int n;
    res.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        res.ready <= 1'b1;
      end else if (snk_idle && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic note_mismatch(input string name, input logic [ACC_WIDTH-1:0] want,
                               input logic [ACC_WIDTH-1:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    energy_word_t want;
    energy_word_t got;
    int           k;
    if (rst_n && res.valid && res.ready) begin
      got.energy[0] = res.act_imp_energy;
      got.energy[1] = res.act_exp_energy;
      got.energy[2] = res.react_imp_energy;
      got.energy[3] = res.react_exp_energy;
      got.est       = res.is_estimated;
      got.best      = res.best_list_type;
      if (energy_q.size() == 0) begin
        $display("%0t: result word with no report pending", $time);
        errors++;
      end else begin
        want = energy_q.pop_front();
        for (k = 0; k < 4; k++) begin
          if (got.energy[k] !== want.energy[k])
            note_mismatch(lane_name[k], want.energy[k], got.energy[k]);
        end
        if (got.est !== want.est)
          note_mismatch("is_estimated", ACC_WIDTH'(want.est), ACC_WIDTH'(got.est));
        if (got.best !== want.best)
          note_mismatch("best_list_type", ACC_WIDTH'(want.best), ACC_WIDTH'(got.best));
      end
    end
  end

  // Reset, tests in turn, drain and verdict
  initial begin
    int k;
    rst_n                  <= 1'b0;
    rpt.valid              <= 1'b0;
    rpt.list_type          <= LT_BASIC;
    rpt.time_ms            <= '0;
    rpt.act_imp_watts      <= '0;
    rpt.act_exp_watts      <= '0;
    rpt.react_imp_var      <= '0;
    rpt.react_exp_var      <= '0;
    rpt.meter_act_imp_wh   <= '0;
    rpt.meter_act_exp_wh   <= '0;
    rpt.meter_react_imp_wh <= '0;
    rpt.meter_react_exp_wh <= '0;
    for (k = 0; k < 4; k++) mdl_energy[k] = '0;
    mdl_last_ms      = '0;
    mdl_last_full_ms = '0;
    mdl_estimated    = 1'b0;
    mdl_best         = LT_BASIC;
    errors           = 0;
    stim_ms          = '0;
    hold_req         = 1'b0;
    src_idle         = 1'b1;
    snk_idle         = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(1140);
    test_backpressure();
    test_full_rate();

    rpt.valid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mea_pkg.sv
rtl/mea_report_if.sv
rtl/mea_result_if.sv
rtl/mea_lane.sv
rtl/meter_energy_accumulator.sv
sim/tb.sv
